FILE: rtl/hunt_bisect_table_locate_defines.svh
// Assertion macros shared by the table locator RTL.
`ifndef HUNT_BISECT_TABLE_LOCATE_DEFINES_SVH
`define HUNT_BISECT_TABLE_LOCATE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on clk and disabled during reset.
`define HBTL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled during reset.
`define HBTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HBTL_ASSERT_IMPLY(label, ante, cons, msg)
`define HBTL_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: rtl/hbtl_pkg.sv
// Shared constants and codes for the hunt-and-bisection table locator.
`default_nettype none

package hbtl_pkg;

  // Default number of table entries.
  localparam int TABLE_DEPTH_DEF = 1024;

  // Fixed field widths of the request, result and configuration ports.
  localparam int KEY_W   = 32;
  localparam int INDEX_W = 10;
  localparam int SIZE_W  = 11;

  // Reset value of the table size register.
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 11'd1024;

  // Request operation codes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOCATE = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/hunt_bisect_table_locate.sv
// Hunt-and-bisection locator over an ascending key table held in a synchronous RAM.
`default_nettype none

// A request is taken at a rising edge where start is high and busy is low.
// A write request stores entry_key at entry_index; busy stays low and no
// result follows. A locate request raises busy (unless only one entry is in
// use) and yields exactly one result: out_valid is high for a single cycle with
// out_lower_index, the largest index whose key is at or below query_value (0
// when the query is below entry 0). The receiver cannot stall, so the result
// must be captured in that cycle. The time per locate is set by the single RAM
// read port, one table read per cycle: a guess of 0 or past the last used entry
// runs plain bisection, and a valid guess adds one read for the guess and one
// per hunt step. The table size register is written through cfg_wr_en /
// cfg_wr_data; the user must write it only while idle, as the block does not
// enforce this. It selects how many entries take part in the search.
module hunt_bisect_table_locate #(
  parameter int TABLE_DEPTH = hbtl_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Request channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_op,
  input  wire logic [hbtl_pkg::INDEX_W-1:0] in_entry_index,
  input  wire logic [hbtl_pkg::KEY_W-1:0]   in_entry_key,
  input  wire logic [hbtl_pkg::KEY_W-1:0]   in_query_value,
  input  wire logic [hbtl_pkg::INDEX_W-1:0] in_start_guess,
  // Result channel
  output logic                              out_valid,
  output logic [hbtl_pkg::INDEX_W-1:0]      out_lower_index,
  // Configuration
  input  wire logic                         cfg_wr_en,
  input  wire logic [hbtl_pkg::SIZE_W-1:0]  cfg_wr_data
);

  `include "hunt_bisect_table_locate_defines.svh"

  // Address width, search index width and a common compare width.
  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW  = AW + 2;
  localparam int CW0 = (IW > hbtl_pkg::INDEX_W) ? IW : hbtl_pkg::INDEX_W;
  localparam int CW  = (CW0 > hbtl_pkg::SIZE_W) ? CW0 : hbtl_pkg::SIZE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GUESS,
    S_UP,
    S_DOWN,
    S_BISECT
  } state_t;

  state_t                      state_r,      state_nxt;
  logic [IW-1:0]               lo_r,         lo_nxt;
  logic [IW-1:0]               hi_r,         hi_nxt;
  logic [IW-1:0]               stride_r,     stride_nxt;
  logic [IW-1:0]               mid_r,        mid_nxt;
  logic [hbtl_pkg::KEY_W-1:0]  query_r,      query_nxt;
  logic                        out_valid_r,  out_valid_nxt;
  logic [hbtl_pkg::INDEX_W-1:0] out_idx_r,   out_idx_nxt;
  logic [hbtl_pkg::SIZE_W-1:0] table_size_r;

  // Key RAM with a registered read port.
  logic [hbtl_pkg::KEY_W-1:0]  key_mem [TABLE_DEPTH];
  logic [hbtl_pkg::KEY_W-1:0]  rdata_r;
  logic                        rd_en;
  logic [IW-1:0]               rd_addr_w;
  logic                        mem_we;
  logic [CW-1:0]               wr_idx_cw;

  logic [CW-1:0]               size_cw;
  logic [IW-1:0]               n_w;
  logic [CW-1:0]               guess_cw;
  logic                        key_le_q;
  logic [IW-1:0]               sum_w;
  logic [IW-1:0]               stride_dbl;
  logic                        go_bis;
  logic                        done;
  logic [IW-1:0]               done_idx;
  logic [CW-1:0]               done_idx_cw;

  // Number of entries in use, clamped to 1..TABLE_DEPTH.
  always_comb begin
    size_cw = CW'(table_size_r);
    if (size_cw == '0) begin
      n_w = IW'(1);
    end else if (size_cw > CW'(TABLE_DEPTH)) begin
      n_w = IW'(TABLE_DEPTH);
    end else begin
      n_w = IW'(size_cw);
    end
  end

  assign guess_cw  = CW'(in_start_guess);
  assign wr_idx_cw = CW'(in_entry_index);
  assign key_le_q  = (query_r >= rdata_r);
  assign stride_dbl = stride_r << 1;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_lower_index = out_idx_r;

  // Search sequencer: one table read per cycle, compare on the returned key.
  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    stride_nxt    = stride_r;
    mid_nxt       = mid_r;
    query_nxt     = query_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    rd_en         = 1'b0;
    rd_addr_w     = '0;
    mem_we        = 1'b0;
    sum_w         = '0;
    go_bis        = 1'b0;
    done          = 1'b0;
    done_idx      = lo_r;
    done_idx_cw   = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_op == hbtl_pkg::OP_LOCATE) begin
            query_nxt = in_query_value;
            if ((guess_cw == '0) || (guess_cw >= CW'(n_w))) begin
              // No usable guess: bisect over the whole table.
              lo_nxt = '0;
              hi_nxt = n_w;
              go_bis = 1'b1;
            end else begin
              lo_nxt    = IW'(guess_cw);
              rd_en     = 1'b1;
              rd_addr_w = IW'(guess_cw);
              state_nxt = S_GUESS;
            end
          end else if (wr_idx_cw < CW'(TABLE_DEPTH)) begin
            mem_we = 1'b1;
          end
        end
      end

      S_GUESS: begin
        if (key_le_q) begin
          if (lo_r == n_w - IW'(1)) begin
            // Guess is the last entry and the query is not below it.
            done     = 1'b1;
            done_idx = lo_r;
          end else begin
            hi_nxt     = lo_r + IW'(1);
            stride_nxt = IW'(1);
            rd_en      = 1'b1;
            rd_addr_w  = lo_r + IW'(1);
            state_nxt  = S_UP;
          end
        end else begin
          hi_nxt     = lo_r;
          stride_nxt = IW'(2);
          if (lo_r <= IW'(2)) begin
            lo_nxt = '0;
            go_bis = 1'b1;
          end else begin
            lo_nxt    = lo_r - IW'(2);
            rd_en     = 1'b1;
            rd_addr_w = lo_r - IW'(2);
            state_nxt = S_DOWN;
          end
        end
      end

      S_UP: begin
        if (key_le_q) begin
          // Move the bracket up and double the stride, clamped at the table end.
          lo_nxt     = hi_r;
          stride_nxt = stride_dbl;
          sum_w      = hi_r + stride_dbl;
          if (sum_w >= n_w) begin
            hi_nxt = n_w;
            go_bis = 1'b1;
          end else begin
            hi_nxt    = sum_w;
            rd_en     = 1'b1;
            rd_addr_w = sum_w;
          end
        end else begin
          go_bis = 1'b1;
        end
      end

      S_DOWN: begin
        if (!key_le_q) begin
          // Move the bracket down and double the stride, clamped at entry 0.
          hi_nxt     = lo_r;
          stride_nxt = stride_dbl;
          if (stride_dbl >= lo_r) begin
            lo_nxt = '0;
            go_bis = 1'b1;
          end else begin
            lo_nxt    = lo_r - stride_dbl;
            rd_en     = 1'b1;
            rd_addr_w = lo_r - stride_dbl;
          end
        end else begin
          go_bis = 1'b1;
        end
      end

      S_BISECT: begin
        if (key_le_q) begin
          lo_nxt = mid_r;
        end else begin
          hi_nxt = mid_r;
        end
        go_bis = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Bisection step: read the midpoint, or finish once the bracket is tight.
    if (go_bis) begin
      if ((hi_nxt - lo_nxt) > IW'(1)) begin
        sum_w     = lo_nxt + hi_nxt;
        mid_nxt   = sum_w >> 1;
        rd_en     = 1'b1;
        rd_addr_w = sum_w >> 1;
        state_nxt = S_BISECT;
      end else begin
        done     = 1'b1;
        done_idx = lo_nxt;
      end
    end

    // Present the result for one cycle and return to idle.
    if (done) begin
      done_idx_cw   = CW'(done_idx);
      out_valid_nxt = 1'b1;
      out_idx_nxt   = done_idx_cw[hbtl_pkg::INDEX_W-1:0];
      state_nxt     = S_IDLE;
    end
  end

  // State, search registers and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      table_size_r <= hbtl_pkg::TABLE_SIZE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        table_size_r <= cfg_wr_data;
      end
    end
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    stride_r  <= stride_nxt;
    mid_r     <= mid_nxt;
    query_r   <= query_nxt;
    out_idx_r <= out_idx_nxt;
  end

  // Key RAM: one write port for table loads, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[wr_idx_cw[AW-1:0]] <= in_entry_key;
    end
    if (rd_en) begin
      rdata_r <= key_mem[rd_addr_w[AW-1:0]];
    end
  end

  // Checks on the sequencer.
  `HBTL_ASSERT_IMPLY(a_result_when_idle, out_valid_r, state_r == S_IDLE, "result while busy")
  `HBTL_ASSERT_NEXT(a_locate_goes_busy, start && !busy && in_op == hbtl_pkg::OP_LOCATE && n_w > IW'(1), busy || out_valid_r, "locate request dropped")
  `HBTL_ASSERT_NEXT(a_write_no_result, start && !busy && in_op == hbtl_pkg::OP_WRITE, !out_valid_r && !busy, "write request gave a result")
  `HBTL_ASSERT_IMPLY(a_read_in_range, rd_en, rd_addr_w < IW'(TABLE_DEPTH), "table read out of range")
  `HBTL_ASSERT_IMPLY(a_bracket_order, state_r == S_BISECT, lo_r < mid_r && mid_r < hi_r, "bisection bracket broken")

endmodule

`default_nettype wire
